// File: hdl/bht_pkg.sv
// Shared types and constants of the bucketed hash table unit.
`default_nettype none

package bht_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 9;
    localparam int REMOVED_W = 4;

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 9'd256;

    // remainder unit: quotient bits retired per cycle
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_CYCLES    = KEY_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_BUCKET_COUNT = 2'd0;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_bht_in;

    typedef struct packed {
        t_status                status;
        logic [VAL_W-1:0]       found_value;
        logic [REMOVED_W-1:0]   removed_count;
    } t_bht_out;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    ins_write;
        logic    scan_adv;
        logic    del_step;
        logic    clr_step;
        logic    finish;
        logic    hit;
        t_status st;
    } t_bht_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    mod_last;
        logic    fill_full;
        logic    fill_zero;
        logic    match;
        logic    scan_last;
        logic    none_removed;
        logic    clr_last;
    } t_bht_sts;

endpackage

`default_nettype wire

// File: hdl/bht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/bht_ctrl.sv
// Operation sequencer of the bucketed hash table unit.
`default_nettype none

module bht_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bht_pkg::t_bht_sts i_sts,
    output bht_pkg::t_bht_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_done
);

    import bht_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_FILL,
        S_DECIDE,
        S_SCAN,
        S_CLEAR
    } t_state;

    t_state   r_state, n_state;
    logic     r_busy, r_done;
    t_bht_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.st  = ST_OK;
        case (r_state)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                case (i_sts.action)
                    ACT_INSERT: begin
                        cmd.finish = 1'b1;
                        if (i_sts.fill_full) begin
                            cmd.st = ST_FULL;
                        end else begin
                            cmd.ins_write = 1'b1;
                        end
                    end
                    ACT_LOOKUP, ACT_DELETE: begin
                        if (i_sts.fill_zero) begin
                            cmd.finish = 1'b1;
                            cmd.st     = ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    ACT_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.action == ACT_LOOKUP) begin
                    if (i_sts.match) begin
                        cmd.finish = 1'b1;
                        cmd.hit    = 1'b1;
                    end else if (i_sts.scan_last) begin
                        cmd.finish = 1'b1;
                        cmd.st     = ST_NOT_FOUND;
                    end else begin
                        cmd.scan_adv = 1'b1;
                    end
                end else begin
                    cmd.del_step = 1'b1;
                    if (i_sts.scan_last) begin
                        cmd.finish = 1'b1;
                        cmd.st     = i_sts.none_removed ? ST_NOT_FOUND : ST_OK;
                    end else begin
                        cmd.scan_adv = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    cmd.finish = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cmd.finish) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= cmd.finish;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hdl/bht_dp.sv
// Datapath: remainder unit, fill and slot RAMs, bucket scan and result register.
`default_nettype none

module bht_dp #(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bht_pkg::t_bht_cmd            i_cmd,
    input  wire bht_pkg::t_bht_in             i_item,
    input  wire logic [bht_pkg::CNT_W-1:0]    i_bucket_count,
    output bht_pkg::t_bht_sts                 o_sts,
    output bht_pkg::t_bht_out                 o_result
);

    import bht_pkg::*;

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FW  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int SAW = BW + SW;

    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);
    localparam logic [FW-1:0] SLOTS_F  = FW'(SLOTS_PER_BUCKET);

    t_action                r_action;
    logic [KEY_W-1:0]       r_key, r_key_sh;
    logic [VAL_W-1:0]       r_value;
    logic [CNT_W-1:0]       r_rem, r_div;
    logic [MOD_CNT_W-1:0]   r_mod_cnt;
    logic [FW-1:0]          r_idx, r_w, r_removed;
    logic [BW-1:0]          r_clr_idx;
    t_bht_out               r_result;

    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W-1:0]       step_rem;
    logic [KEY_W-1:0]       step_sh;
    logic [CNT_W:0]         trial;

    logic [BW-1:0]          bucket;
    logic [FW-1:0]          fill, n_idx, n_w, n_removed;
    logic                   match, scan_last;

    logic                   fill_we;
    logic [BW-1:0]          fill_waddr;
    logic [FW-1:0]          fill_wdata;
    logic                   slot_we;
    logic [SAW-1:0]         slot_waddr, slot_raddr;
    logic [KEY_W+VAL_W-1:0] slot_wdata, slot_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [VAL_W-1:0]       rd_val;

    // zero means one bucket; anything above the table size is clamped
    always_comb begin
        if (i_bucket_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(i_bucket_count) > BUCKETS) begin
            eff_count = CNT_W'(BUCKETS);
        end else begin
            eff_count = i_bucket_count;
        end
    end

    // restoring remainder, MOD_STEP_BITS key bits per cycle, MSB first
    always_comb begin
        step_rem = r_rem;
        step_sh  = r_key_sh;
        trial    = '0;
        for (int k = 0; k < MOD_STEP_BITS; k++) begin
            trial   = {step_rem, step_sh[KEY_W-1]};
            step_sh = step_sh << 1;
            if (trial >= {1'b0, r_div}) begin
                step_rem = CNT_W'(trial - {1'b0, r_div});
            end else begin
                step_rem = trial[CNT_W-1:0];
            end
        end
    end

    assign bucket = BW'(r_rem);
    assign rd_key = slot_rdata[KEY_W+VAL_W-1:VAL_W];
    assign rd_val = slot_rdata[VAL_W-1:0];

    assign match     = (rd_key == r_key);
    assign scan_last = ((r_idx + FW'(1)) == fill);

    // read address always tracks the index that r_idx holds next cycle
    always_comb begin
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.scan_adv) begin
            n_idx = r_idx + FW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign n_w       = r_w + FW'(i_cmd.del_step && !match);
    assign n_removed = r_removed + FW'(i_cmd.del_step && match);

    assign slot_raddr = {bucket, n_idx[SW-1:0]};
    assign slot_we    = i_cmd.ins_write || (i_cmd.del_step && !match);
    assign slot_waddr = i_cmd.ins_write ? {bucket, fill[SW-1:0]} : {bucket, r_w[SW-1:0]};
    assign slot_wdata = i_cmd.ins_write ? {r_key, r_value} : slot_rdata;

    assign fill_we    = i_cmd.clr_step || i_cmd.ins_write || (i_cmd.del_step && scan_last);
    assign fill_waddr = i_cmd.clr_step ? r_clr_idx : bucket;

    always_comb begin
        if (i_cmd.clr_step) begin
            fill_wdata = '0;
        end else if (i_cmd.ins_write) begin
            fill_wdata = fill + FW'(1);
        end else begin
            fill_wdata = n_w;
        end
    end

    bht_ram #(
        .WIDTH (FW),
        .DEPTH (2 ** BW)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (bucket),
        .o_rdata (fill)
    );

    bht_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (2 ** SAW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_div     <= CNT_W'(1);
            r_mod_cnt <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rem     <= '0;
                r_div     <= eff_count;
                r_mod_cnt <= '0;
                r_clr_idx <= '0;
            end else begin
                if (i_cmd.mod_step) begin
                    r_rem     <= step_rem;
                    r_mod_cnt <= r_mod_cnt + MOD_CNT_W'(1);
                end
                if (i_cmd.clr_step) begin
                    r_clr_idx <= r_clr_idx + BW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_action  <= i_item.action;
            r_key     <= i_item.key;
            r_value   <= i_item.value;
            r_key_sh  <= i_item.key;
            r_w       <= '0;
            r_removed <= '0;
        end else begin
            if (i_cmd.mod_step) begin
                r_key_sh <= step_sh;
            end
            if (i_cmd.del_step) begin
                r_w       <= n_w;
                r_removed <= n_removed;
            end
        end
        if (i_cmd.finish) begin
            r_result.status        <= i_cmd.st;
            r_result.found_value   <= i_cmd.hit ? rd_val : '0;
            r_result.removed_count <= (r_action == ACT_DELETE) ? REMOVED_W'(n_removed) : '0;
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.action       = r_action;
        o_sts.mod_last     = (r_mod_cnt == MOD_CNT_W'(MOD_CYCLES - 1));
        o_sts.fill_full    = (fill >= SLOTS_F);
        o_sts.fill_zero    = (fill == '0);
        o_sts.match        = match;
        o_sts.scan_last    = scan_last;
        o_sts.none_removed = (n_removed == '0);
        o_sts.clr_last     = (r_clr_idx == LAST_BKT);
    end

    assign o_result = r_result;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < r_div)
        else $error("remainder not below divisor");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_we |-> (fill_wdata <= SLOTS_F))
        else $error("bucket fill written beyond slot count");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del_step |-> (r_w <= r_idx))
        else $error("compaction write pointer ahead of scan");

    // the last slot of a scan may be rewritten in place; only the read ahead matters
    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot_we && i_cmd.del_step && i_cmd.scan_adv) |-> (slot_waddr != slot_raddr))
        else $error("compaction write hits slot being read ahead");

endmodule

`default_nettype wire

// File: hdl/bucketed_hash_table_unit.sv
// Top level of the bucketed hash table unit: config register, sequencer and datapath.
`default_nettype none

// Bucketed hash table of 32-bit key/value pairs, BUCKETS buckets of
// SLOTS_PER_BUCKET slots. An operation is taken when start is high and busy is
// low; its single result appears in o_result with o_done, a one-cycle strobe
// which cannot be held off. busy stays high through the remainder unit and the
// fill RAM read on every operation; a lookup or delete then scans the bucket one
// slot at a time (at most SLOTS_PER_BUCKET slots), and a clear then sweeps all
// BUCKETS buckets. The remainder unit reduces the key modulo the bucket count, 4
// key bits per cycle; the slot RAM's single read port sets the one-slot-per-cycle
// scan; a clear sweeps the fill RAM one bucket per cycle. After reset busy stays
// high while the fill RAM is cleared; configuration writes are taken throughout.
module bucketed_hash_table_unit #(
    parameter int BUCKETS          = 256,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire bht_pkg::t_bht_in              i_cmd,
    output logic                               o_done,
    output bht_pkg::t_bht_out                  o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bht_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bht_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bht_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import bht_pkg::*;

    logic [CNT_W-1:0] r_bucket_count;
    t_bht_cmd         cmd;
    t_bht_sts         sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_BUCKET_COUNT)) begin
            r_bucket_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_BUCKET_COUNT) ? PDATA_W'(r_bucket_count) : '0;
    assign pready = 1'b1;

    bht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bht_dp #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_cmd),
        .i_bucket_count (r_bucket_count),
        .o_sts          (sts),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire
